// File: rtl/gdor_pkg.sv
package gdor_pkg;

   localparam int VERTEX_LIMIT = 64;
   localparam int IW = 6;
   localparam int CW = 7;
   localparam int ROW_W = 64;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_EDGE = 2'd1;
   localparam logic [1:0] OP_SORT = 2'd2;

   localparam logic REG_VERTEX_COUNT = 1'b0;
   localparam logic REG_ASCENDING = 1'b1;

   typedef enum logic [3:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_EDGE,
      CELL_INIT,
      CELL_DEGREE,
      CELL_KEYLOAD,
      CELL_RANK,
      CELL_POSLOAD,
      CELL_RELABEL,
      CELL_COMMIT,
      CELL_SORT,
      CELL_ROTATE
   } cell_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DEGREE,
      ST_KEYLOAD,
      ST_RANK,
      ST_POSLOAD,
      ST_RELABEL,
      ST_COMMIT,
      ST_SORT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      cell_op_type   op;
      logic          in_range;
      logic          parity;
      logic          ascending;
      logic [CW-1:0] count;
      logic [IW-1:0] first;
      logic [IW-1:0] second;
      logic [IW-1:0] bcast;
   } cell_ctl_type;

endpackage

// File: rtl/gdor_cell.sv
module gdor_cell
   import gdor_pkg::*;
#(
   parameter int MAX_VERTICES = VERTEX_LIMIT,
   parameter int IDX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cell_ctl_type            ctl,
   input  logic [MAX_VERTICES-1:0] left_row,
   input  logic                    left_loop,
   input  logic [CW-1:0]           left_deg,
   input  logic [IW-1:0]           left_orig,
   input  logic [IW-1:0]           left_rank,
   input  logic [CW-1:0]           left_key_deg,
   input  logic [IW-1:0]           left_key_idx,
   input  logic [MAX_VERTICES-1:0] right_row,
   input  logic                    right_loop,
   input  logic [CW-1:0]           right_deg,
   input  logic [IW-1:0]           right_orig,
   input  logic [IW-1:0]           right_rank,
   input  logic [IW-1:0]           right_pos,
   output logic [MAX_VERTICES-1:0] row,
   output logic                    loop,
   output logic [CW-1:0]           deg,
   output logic [IW-1:0]           orig,
   output logic [IW-1:0]           rank,
   output logic [CW-1:0]           key_deg,
   output logic [IW-1:0]           key_idx,
   output logic [IW-1:0]           pos
);

   localparam logic [IW-1:0] ID = IW'(IDX);
   localparam logic ID_ODD = 1'(IDX % 2);
   localparam logic [MAX_VERTICES-1:0] ONE = MAX_VERTICES'(1);

   logic [MAX_VERTICES-1:0] row_ff, row_in, new_ff, new_in;
   logic                    loop_ff, loop_in;
   logic [CW-1:0]           deg_ff, deg_in, kdeg_ff, kdeg_in;
   logic [IW-1:0]           orig_ff, orig_in, rank_ff, rank_in;
   logic [IW-1:0]           kidx_ff, kidx_in, pos_ff, pos_in;
   logic                    own_valid, key_less, take_left, take_right;

   // slot key orders before own key
   always_comb begin
      own_valid = {1'b0, orig_ff} < ctl.count;
      if (kdeg_ff == deg_ff) begin
         key_less = kidx_ff < orig_ff;
      end else if (ctl.ascending) begin
         key_less = kdeg_ff < deg_ff;
      end else begin
         key_less = kdeg_ff > deg_ff;
      end
      key_less = key_less && ({1'b0, kidx_ff} < ctl.count);
   end

   // odd-even transposition partners
   always_comb begin
      take_right = 1'b0;
      take_left = 1'b0;
      if (ID_ODD == ctl.parity) begin
         take_right = (IDX < MAX_VERTICES - 1) && (rank_ff > right_rank);
      end else begin
         take_left = (IDX > 0) && (left_rank > rank_ff);
      end
   end

   // next state of the cell
   always_comb begin
      row_in = row_ff;
      new_in = new_ff;
      loop_in = loop_ff;
      deg_in = deg_ff;
      orig_in = orig_ff;
      rank_in = rank_ff;
      kdeg_in = kdeg_ff;
      kidx_in = kidx_ff;
      pos_in = pos_ff;
      case (ctl.op)
         CELL_CLEAR: begin
            row_in = '0;
            loop_in = 1'b0;
         end
         CELL_EDGE: begin
            if (ctl.first != ctl.second) begin
               if (ID == ctl.first) row_in = row_in | (ONE << ctl.second);
               if (ID == ctl.second) row_in = row_in | (ONE << ctl.first);
            end else if (ID == ctl.first) begin
               loop_in = 1'b1;
            end
         end
         CELL_INIT: begin
            deg_in = '0;
            rank_in = '0;
            new_in = '0;
            orig_in = ID;
         end
         CELL_DEGREE: begin
            deg_in = deg_ff + CW'(row_ff[0] & ctl.in_range);
            row_in = {row_ff[0], row_ff[MAX_VERTICES-1:1]};
         end
         CELL_KEYLOAD: begin
            kdeg_in = deg_ff;
            kidx_in = orig_ff;
         end
         CELL_RANK: begin
            rank_in = own_valid ? rank_ff + IW'(key_less) : orig_ff;
            kdeg_in = left_key_deg;
            kidx_in = left_key_idx;
         end
         CELL_POSLOAD: pos_in = rank_ff;
         CELL_RELABEL: begin
            if (row_ff[0] && ctl.in_range && own_valid) begin
               new_in = new_ff | (ONE << ctl.bcast);
            end
            row_in = {row_ff[0], row_ff[MAX_VERTICES-1:1]};
            pos_in = right_pos;
         end
         CELL_COMMIT: begin
            row_in = new_ff;
            loop_in = loop_ff & own_valid;
         end
         CELL_SORT: begin
            if (take_right) begin
               row_in = right_row;
               loop_in = right_loop;
               deg_in = right_deg;
               orig_in = right_orig;
               rank_in = right_rank;
            end else if (take_left) begin
               row_in = left_row;
               loop_in = left_loop;
               deg_in = left_deg;
               orig_in = left_orig;
               rank_in = left_rank;
            end
         end
         CELL_ROTATE: begin
            row_in = right_row;
            loop_in = right_loop;
            deg_in = right_deg;
            orig_in = right_orig;
            rank_in = right_rank;
         end
         default: ;
      endcase
   end

   // graph store part is cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         loop_ff <= 1'b0;
      end else begin
         row_ff <= row_in;
         loop_ff <= loop_in;
      end
   end

   // sort working registers
   always_ff @(posedge clock) begin
      new_ff <= new_in;
      deg_ff <= deg_in;
      orig_ff <= orig_in;
      rank_ff <= rank_in;
      kdeg_ff <= kdeg_in;
      kidx_ff <= kidx_in;
      pos_ff <= pos_in;
   end

   assign row = row_ff;
   assign loop = loop_ff;
   assign deg = deg_ff;
   assign orig = orig_ff;
   assign rank = rank_ff;
   assign key_deg = kdeg_ff;
   assign key_idx = kidx_ff;
   assign pos = pos_ff;

endmodule

// File: rtl/graph_degree_order_relabel.sv
// Graph store with degree ordering and relabelling.
// Input channel req_*: operation 0 clears the graph, 1 adds the edge
// first_vertex/second_vertex (equal ends set the loop mark, ends at or
// beyond the vertex count are ignored), 2 sorts by degree and emits.
// Clear and add-edge leave the block idle, so one such transfer per cycle while no sort runs.
// A sort runs through the row of cells in passes over every cell:
// degree count, ranking, relabel, odd-even exchange and the emit
// rotation, plus four single steps.
// Rows leave on rsp_* one per transfer, from the head cell, last_row on
// the final one. When the receiver stalls, the emit rotation holds; one
// result waits in the output register meanwhile.
// Configuration csr_*: index 0 vertex count, 1 ascending order; always
// ready, to be written only while the block is idle.
// Reset (synchronous) empties the graph, sets the vertex count to
// MAX_VERTICES and falling degree order.
module graph_degree_order_relabel
   import gdor_pkg::*;
#(
   parameter int MAX_VERTICES = VERTEX_LIMIT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_operation,
   input  logic [IW-1:0]    req_first_vertex,
   input  logic [IW-1:0]    req_second_vertex,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [IW-1:0]    rsp_row_index,
   output logic [IW-1:0]    rsp_original_vertex,
   output logic [ROW_W-1:0] rsp_row_bits,
   output logic [IW-1:0]    rsp_vertex_degree,
   output logic             rsp_loop_mark,
   output logic             rsp_last_row,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [CW-1:0]    csr_wdata
);

   localparam int M = MAX_VERTICES;
   localparam logic [CW-1:0] LAST_STEP = CW'(M - 1);
   localparam logic [CW-1:0] MAX_COUNT = CW'(M);

   logic [M-1:0]  c_row [M];
   logic          c_loop [M];
   logic [CW-1:0] c_deg [M];
   logic [IW-1:0] c_orig [M];
   logic [IW-1:0] c_rank [M];
   logic [CW-1:0] c_kdeg [M];
   logic [IW-1:0] c_kidx [M];
   logic [IW-1:0] c_pos [M];

   state_type     state_ff, state_in;
   logic [CW-1:0] step_ff, step_in;
   logic [CW-1:0] vcount_ff;
   logic          asc_ff;
   logic [CW-1:0] count;
   cell_ctl_type  ctl;
   logic          accept, out_free, emit_row, load_out, step_last;

   logic             rsp_valid_ff;
   logic [IW-1:0]    rsp_index_ff, rsp_orig_ff, rsp_deg_ff;
   logic [ROW_W-1:0] rsp_row_ff;
   logic             rsp_loop_ff, rsp_last_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= MAX_COUNT;
         asc_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_VERTEX_COUNT: vcount_ff <= csr_wdata;
            REG_ASCENDING: asc_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // vertex count in use, clamped
   always_comb begin
      if (vcount_ff == '0) begin
         count = CW'(1);
      end else if (vcount_ff > MAX_COUNT) begin
         count = MAX_COUNT;
      end else begin
         count = vcount_ff;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit_row = step_ff < count;
   assign step_last = (step_ff == LAST_STEP);

   // sequencer: next state and cell commands
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      load_out = 1'b0;
      ctl.op = CELL_HOLD;
      ctl.in_range = step_ff < count;
      ctl.parity = step_ff[0];
      ctl.ascending = asc_ff;
      ctl.count = count;
      ctl.first = req_first_vertex;
      ctl.second = req_second_vertex;
      ctl.bcast = c_pos[0];
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (accept) begin
               case (req_operation)
                  OP_CLEAR: ctl.op = CELL_CLEAR;
                  OP_EDGE: begin
                     if (({1'b0, req_first_vertex} < count) &&
                         ({1'b0, req_second_vertex} < count)) begin
                        ctl.op = CELL_EDGE;
                     end
                  end
                  OP_SORT: begin
                     ctl.op = CELL_INIT;
                     state_in = ST_DEGREE;
                  end
                  default: ;
               endcase
            end
         end
         ST_DEGREE: begin
            ctl.op = CELL_DEGREE;
            step_in = step_ff + 1'b1;
            if (step_last) begin
               step_in = '0;
               state_in = ST_KEYLOAD;
            end
         end
         ST_KEYLOAD: begin
            ctl.op = CELL_KEYLOAD;
            state_in = ST_RANK;
         end
         ST_RANK: begin
            ctl.op = CELL_RANK;
            step_in = step_ff + 1'b1;
            if (step_last) begin
               step_in = '0;
               state_in = ST_POSLOAD;
            end
         end
         ST_POSLOAD: begin
            ctl.op = CELL_POSLOAD;
            state_in = ST_RELABEL;
         end
         ST_RELABEL: begin
            ctl.op = CELL_RELABEL;
            step_in = step_ff + 1'b1;
            if (step_last) begin
               step_in = '0;
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            ctl.op = CELL_COMMIT;
            state_in = ST_SORT;
         end
         ST_SORT: begin
            ctl.op = CELL_SORT;
            step_in = step_ff + 1'b1;
            if (step_last) begin
               step_in = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // head cell leaves through the output register, ring turns
            if (!emit_row || out_free) begin
               ctl.op = CELL_ROTATE;
               load_out = emit_row;
               step_in = step_ff + 1'b1;
               if (step_last) begin
                  step_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

   // chain of cells, closed into a ring
   for (genvar i = 0; i < M; i++) begin : g_cell
      localparam int L = (i + M - 1) % M;
      localparam int R = (i + 1) % M;
      gdor_cell #(
         .MAX_VERTICES(M),
         .IDX(i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_row    (c_row[L]),
         .left_loop   (c_loop[L]),
         .left_deg    (c_deg[L]),
         .left_orig   (c_orig[L]),
         .left_rank   (c_rank[L]),
         .left_key_deg(c_kdeg[L]),
         .left_key_idx(c_kidx[L]),
         .right_row   (c_row[R]),
         .right_loop  (c_loop[R]),
         .right_deg   (c_deg[R]),
         .right_orig  (c_orig[R]),
         .right_rank  (c_rank[R]),
         .right_pos   (c_pos[R]),
         .row         (c_row[i]),
         .loop        (c_loop[i]),
         .deg         (c_deg[i]),
         .orig        (c_orig[i]),
         .rank        (c_rank[i]),
         .key_deg     (c_kdeg[i]),
         .key_idx     (c_kidx[i]),
         .pos         (c_pos[i])
      );
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_index_ff <= step_ff[IW-1:0];
         rsp_orig_ff <= c_orig[0];
         rsp_row_ff <= ROW_W'(c_row[0]);
         rsp_deg_ff <= c_deg[0][IW-1:0];
         rsp_loop_ff <= c_loop[0];
         rsp_last_ff <= (step_ff + 1'b1) == count;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_row_index = rsp_index_ff;
   assign rsp_original_vertex = rsp_orig_ff;
   assign rsp_row_bits = rsp_row_ff;
   assign rsp_vertex_degree = rsp_deg_ff;
   assign rsp_loop_mark = rsp_loop_ff;
   assign rsp_last_row = rsp_last_ff;

   // a row other than the last is followed by more of the emit pass
   a_more_rows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_row) |-> (state_ff == ST_EMIT))
      else $error("emit pass ended before the last row");

   // exchange pass leaves the head cell holding the expected position
   a_head_rank: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && emit_row) |-> (c_rank[0] == step_ff[IW-1:0]))
      else $error("cell order does not match rank");

   // no new item while rows are being produced
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (load_out) |-> (!req_ready && state_ff == ST_EMIT))
      else $error("row loaded outside the emit pass");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import gdor_pkg::*;

   localparam int NV = 64;
   localparam logic [1:0] OP_SPARE = 2'd3;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [1:0]       req_operation = OP_CLEAR;
   logic [IW-1:0]    req_first_vertex = '0;
   logic [IW-1:0]    req_second_vertex = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [IW-1:0]    rsp_row_index;
   logic [IW-1:0]    rsp_original_vertex;
   logic [ROW_W-1:0] rsp_row_bits;
   logic [IW-1:0]    rsp_vertex_degree;
   logic             rsp_loop_mark;
   logic             rsp_last_row;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic             csr_index = REG_VERTEX_COUNT;
   logic [CW-1:0]    csr_wdata = '0;

   graph_degree_order_relabel u_dut (.*);

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   typedef struct packed {
      logic [IW-1:0]    pos;
      logic [IW-1:0]    orig;
      logic [ROW_W-1:0] bits;
      logic [IW-1:0]    deg;
      logic             lp;
      logic             last;
   } sorted_row_type;

   // predictor state
   logic [ROW_W-1:0] graph_rows [NV];
   logic [NV-1:0]    graph_loops;
   logic [CW-1:0]    cfg_count = CW'(NV);
   logic             cfg_rising = 1'b0;
   sorted_row_type   pending_rows [$];
   int               fail_count = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;

   function automatic int active_count();
      if (cfg_count == 0) return 1;
      if (cfg_count > NV) return NV;
      return int'(cfg_count);
   endfunction

   // add the rows a sort causes and relabel the graph
   task automatic predict_sort();
      int            n;
      int            perm [NV];
      int            deg [NV];
      int            t;
      logic [ROW_W-1:0] mask;
      logic [ROW_W-1:0] nrows [NV];
      logic [NV-1:0]    nloops;
      sorted_row_type r;
      n = active_count();
      mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
      for (int i = 0; i < n; i++) begin
         deg[i] = $countones(graph_rows[i] & mask);
         perm[i] = i;
      end
      for (int i = 1; i < n; i++) begin
         for (int j = i; j > 0; j--) begin
            if (cfg_rising ? (deg[perm[j-1]] > deg[perm[j]])
                           : (deg[perm[j-1]] < deg[perm[j]])) begin
               t = perm[j-1]; perm[j-1] = perm[j]; perm[j] = t;
            end else break;
         end
      end
      nloops = '0;
      for (int i = 0; i < NV; i++) nrows[i] = '0;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++)
            if (graph_rows[perm[i]][perm[j]]) nrows[i][j] = 1'b1;
         if (graph_loops[perm[i]]) nloops[i] = 1'b1;
      end
      for (int i = 0; i < NV; i++) graph_rows[i] = nrows[i];
      graph_loops = nloops;
      for (int i = 0; i < n; i++) begin
         r.pos = IW'(i);
         r.orig = IW'(perm[i]);
         r.bits = nrows[i];
         r.deg = IW'(deg[perm[i]]);
         r.lp = nloops[i];
         r.last = (i == n - 1);
         pending_rows.push_back(r);
      end
   endtask

   task automatic predict_item(logic [1:0] op, logic [IW-1:0] a, logic [IW-1:0] b);
      int n;
      n = active_count();
      case (op)
         OP_CLEAR: begin
            for (int i = 0; i < NV; i++) graph_rows[i] = '0;
            graph_loops = '0;
         end
         OP_EDGE: begin
            if (a < n && b < n) begin
               if (a != b) begin
                  graph_rows[a][b] = 1'b1;
                  graph_rows[b][a] = 1'b1;
               end else graph_loops[a] = 1'b1;
            end
         end
         OP_SORT: predict_sort();
         default: ;
      endcase
   endtask

   // send one item and predict at its transfer; valid drops on an idle cycle
   task automatic send_item(logic [1:0] op, logic [IW-1:0] a, logic [IW-1:0] b);
      csr_valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_first_vertex <= a;
      req_second_vertex <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(op, a, b);
      @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [CW-1:0] val);
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_VERTEX_COUNT) cfg_count = val;
      else cfg_rising = val[0];
      @(negedge clock);
   endtask

   // drain all expected rows, then wait for the block to be idle
   task automatic wait_idle();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      @(negedge clock);
      while (pending_rows.size() != 0 || !req_ready || rsp_valid) @(negedge clock);
   endtask

   // receiver stall
   always @(negedge clock)
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);

   // result checking
   always @(posedge clock) begin
      sorted_row_type got, exp_row;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_row_index, rsp_original_vertex, rsp_row_bits,
                 rsp_vertex_degree, rsp_loop_mark, rsp_last_row};
         if (pending_rows.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected row %p", got);
         end else begin
            exp_row = pending_rows.pop_front();
            if (got !== exp_row) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("row mismatch: expected %p got %p", exp_row, got);
            end
         end
      end
   end

   task automatic test_extremes();
      write_reg(REG_VERTEX_COUNT, 7'd64);
      write_reg(REG_ASCENDING, 7'd0);
      send_item(OP_EDGE, 6'd0, 6'd63);
      send_item(OP_EDGE, 6'd63, 6'd63);
      send_item(OP_EDGE, 6'd0, 6'd0);
      send_item(OP_EDGE, 6'd21, 6'd42);
      send_item(OP_EDGE, 6'd42, 6'd1);
      send_item(OP_SPARE, 6'd5, 6'd6);
      send_item(OP_SORT, 6'd0, 6'd0);
      send_item(OP_SORT, 6'd63, 6'd63);
      wait_idle();
   endtask

   task automatic test_count_limits();
      // zero acts as one, above the limit acts as the limit
      write_reg(REG_VERTEX_COUNT, 7'd0);
      send_item(OP_EDGE, 6'd0, 6'd0);
      send_item(OP_EDGE, 6'd0, 6'd1);
      send_item(OP_SORT, 6'd0, 6'd0);
      wait_idle();
      write_reg(REG_VERTEX_COUNT, 7'd127);
      write_reg(REG_ASCENDING, 7'd1);
      send_item(OP_EDGE, 6'd10, 6'd11);
      send_item(OP_SORT, 6'd0, 6'd0);
      wait_idle();
      // bits beyond the count are dropped by the sort
      write_reg(REG_VERTEX_COUNT, 7'd4);
      send_item(OP_EDGE, 6'd3, 6'd4);
      send_item(OP_EDGE, 6'd1, 6'd2);
      send_item(OP_SORT, 6'd0, 6'd0);
      send_item(OP_CLEAR, 6'd0, 6'd0);
      send_item(OP_SORT, 6'd0, 6'd0);
      wait_idle();
   endtask

   task automatic test_random(int items);
      int n;
      int left;
      left = items;
      while (left > 0) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 12);
         write_reg(REG_VERTEX_COUNT, CW'(n));
         write_reg(REG_ASCENDING, CW'($urandom_range(1)));
         if ($urandom_range(3) == 0) begin
            send_item(OP_CLEAR, IW'($urandom), IW'($urandom));
            left--;
         end
         for (int k = $urandom_range(2, 14); k > 0; k--) begin
            if ($urandom_range(9) == 0)
               send_item(2'($urandom), IW'($urandom), IW'($urandom));
            else if ($urandom_range(7) == 0)
               send_item(OP_EDGE, IW'($urandom), IW'($urandom));
            else
               send_item(OP_EDGE, IW'($urandom_range(n - 1)), IW'($urandom_range(n - 1)));
            left--;
         end
         send_item(OP_SORT, IW'($urandom), IW'($urandom));
         left--;
         if ($urandom_range(2) == 0) begin
            send_item(OP_SORT, '0, '0);
            left--;
         end
         wait_idle();
      end
   endtask

   initial begin
      for (int i = 0; i < NV; i++) graph_rows[i] = '0;
      graph_loops = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);
      send_idle_pct = 38; recv_idle_pct = 79;
      test_extremes();
      test_count_limits();
      test_random(70);
      send_idle_pct = 79; recv_idle_pct = 38;
      test_random(70);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(70);
      wait_idle();
      if (fail_count == 0 && pending_rows.size() == 0)
         $display("[graph_degree_order_relabel] OK");
      else
         $display("[graph_degree_order_relabel] ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("[graph_degree_order_relabel] ERROR");
      $finish;
   end

endmodule
